FILE: rtl/pn3_pkg.sv
// Shared types and constants for the 3D noise block.
`default_nettype none
package pn3_pkg;
  localparam int QB = 24;
  localparam int VW = 32;
  typedef logic signed [VW-1:0] q_t;
  localparam q_t QONE = q_t'(32'sd16777216);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/pn3_mul.sv
// Rounded signed Q.24 multiplier, one product per start.
`default_nettype none
module pn3_mul import pn3_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire q_t   a,
  input  wire q_t   b,
  output logic      done,
  output q_t        p
);
  logic        neg_r;
  logic [63:0] prod_r;
  logic        busy_r;
  logic [31:0] ua, ub;
  logic [63:0] rnd;

  assign ua = a[VW-1] ? 32'(-a) : 32'(a);
  assign ub = b[VW-1] ? 32'(-b) : 32'(b);
  assign rnd = (prod_r + 64'(1 << (QB - 1))) >> QB;
  assign p = neg_r ? -q_t'(rnd[VW-1:0]) : q_t'(rnd[VW-1:0]);
  assign done = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
    if (start) begin
      prod_r <= 64'(ua) * 64'(ub);
      neg_r  <= (a[VW-1] != b[VW-1]) && (a != '0) && (b != '0);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pn3_datapath.sv
// Datapath: permutation memory, hash registers, fade/gradient/lerp arithmetic.
`default_nettype none
module pn3_datapath import pn3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [7:0]  wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic [23:0] x_in,
  input  wire logic [23:0] y_in,
  input  wire logic [23:0] z_in,
  input  wire logic [2:0]  step,
  input  wire logic [4:0]  mstep,
  input  wire logic        tab_rd,
  input  wire logic [3:0]  tsel,
  input  wire logic        load,
  input  wire logic        mstart,
  output logic             mdone,
  output logic [15:0]      noise
);
  logic [7:0] mem [256];
  logic [7:0] q_r;
  logic [7:0] xi_r, yi_r, zi_r;
  q_t fx_r, fy_r, fz_r;
  // hash regs: A,B,AA,AB,BA,BB
  logic [7:0] hs_r [6];
  logic [3:0] g_r [8];
  q_t t_r [12];
  q_t ma, mb, mp;
  logic [7:0] ra;

  function automatic q_t frac(input logic [23:0] c);
    logic [QB-1:0] f;
    f = QB'(c[FRAC_BITS-1:0]) << (QB - FRAC_BITS);
    return q_t'({8'd0, f});
  endfunction

  function automatic q_t grad(input logic [3:0] h, input q_t x, input q_t y, input q_t z);
    q_t u, v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // table address by sequence step
  always_comb begin
    case (tsel)
      4'd0: ra = xi_r;
      4'd1: ra = hs_r[0];
      4'd2: ra = hs_r[0] + 8'd1;
      4'd3: ra = xi_r + 8'd1;
      4'd4: ra = hs_r[1];
      4'd5: ra = hs_r[1] + 8'd1;
      4'd6: ra = hs_r[2];
      4'd7: ra = hs_r[4];
      4'd8: ra = hs_r[3];
      4'd9: ra = hs_r[5];
      4'd10: ra = hs_r[2] + 8'd1;
      4'd11: ra = hs_r[4] + 8'd1;
      4'd12: ra = hs_r[3] + 8'd1;
      default: ra = hs_r[5] + 8'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (tab_rd) q_r <= mem[ra];
  end

  // multiplier operand selection; t_r: 0..1 scratch, 2 result, 3..5 fade u,v,w, 6..11 lerp
  always_comb begin
    ma = t_r[0];
    mb = t_r[0];
    case (mstep)
      5'd0: begin ma = fx_r; mb = 6 * fx_r - 15 * QONE; end
      5'd1: begin ma = fx_r; mb = fx_r; end
      5'd2: begin ma = t_r[1]; mb = fx_r; end
      5'd3: begin ma = t_r[1]; mb = t_r[0] + 10 * QONE; end
      5'd4: begin ma = fy_r; mb = 6 * fy_r - 15 * QONE; end
      5'd5: begin ma = fy_r; mb = fy_r; end
      5'd6: begin ma = t_r[1]; mb = fy_r; end
      5'd7: begin ma = t_r[1]; mb = t_r[0] + 10 * QONE; end
      5'd8: begin ma = fz_r; mb = 6 * fz_r - 15 * QONE; end
      5'd9: begin ma = fz_r; mb = fz_r; end
      5'd10: begin ma = t_r[1]; mb = fz_r; end
      5'd11: begin ma = t_r[1]; mb = t_r[0] + 10 * QONE; end
      5'd12: begin ma = t_r[3]; mb = grad(g_r[1], fx_r-QONE, fy_r, fz_r)
                                    - grad(g_r[0], fx_r, fy_r, fz_r); end
      5'd13: begin ma = t_r[3]; mb = grad(g_r[3], fx_r-QONE, fy_r-QONE, fz_r)
                                    - grad(g_r[2], fx_r, fy_r-QONE, fz_r); end
      5'd14: begin ma = t_r[3]; mb = grad(g_r[5], fx_r-QONE, fy_r, fz_r-QONE)
                                    - grad(g_r[4], fx_r, fy_r, fz_r-QONE); end
      5'd15: begin ma = t_r[3]; mb = grad(g_r[7], fx_r-QONE, fy_r-QONE, fz_r-QONE)
                                    - grad(g_r[6], fx_r, fy_r-QONE, fz_r-QONE); end
      5'd16: begin ma = t_r[4]; mb = t_r[7] - t_r[6]; end
      5'd17: begin ma = t_r[4]; mb = t_r[9] - t_r[8]; end
      default: begin ma = t_r[5]; mb = t_r[11] - t_r[10]; end
    endcase
  end

  pn3_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                 .done(mdone), .p(mp));

  // stash coordinates, table reads and products
  always_ff @(posedge clk) begin
    if (load) begin
      xi_r <= 8'(x_in >> FRAC_BITS);
      yi_r <= 8'(y_in >> FRAC_BITS);
      zi_r <= 8'(z_in >> FRAC_BITS);
      fx_r <= frac(x_in);
      fy_r <= frac(y_in);
      fz_r <= frac(z_in);
    end
    if (step != 3'd0) begin
      case (tsel)
        4'd0: hs_r[0] <= q_r + yi_r;
        4'd1: hs_r[2] <= q_r + zi_r;
        4'd2: hs_r[3] <= q_r + zi_r;
        4'd3: hs_r[1] <= q_r + yi_r;
        4'd4: hs_r[4] <= q_r + zi_r;
        4'd5: hs_r[5] <= q_r + zi_r;
        4'd6: g_r[0] <= q_r[3:0];
        4'd7: g_r[1] <= q_r[3:0];
        4'd8: g_r[2] <= q_r[3:0];
        4'd9: g_r[3] <= q_r[3:0];
        4'd10: g_r[4] <= q_r[3:0];
        4'd11: g_r[5] <= q_r[3:0];
        4'd12: g_r[6] <= q_r[3:0];
        default: g_r[7] <= q_r[3:0];
      endcase
    end
    if (mdone) begin
      case (mstep)
        5'd0, 5'd4, 5'd8: t_r[0] <= mp;
        5'd1, 5'd2, 5'd5, 5'd6, 5'd9, 5'd10: t_r[1] <= mp;
        5'd3: t_r[3] <= mp;
        5'd7: t_r[4] <= mp;
        5'd11: t_r[5] <= mp;
        5'd12: t_r[6] <= grad(g_r[0], fx_r, fy_r, fz_r) + mp;
        5'd13: t_r[7] <= grad(g_r[2], fx_r, fy_r-QONE, fz_r) + mp;
        5'd14: t_r[8] <= grad(g_r[4], fx_r, fy_r, fz_r-QONE) + mp;
        5'd15: t_r[9] <= grad(g_r[6], fx_r, fy_r-QONE, fz_r-QONE) + mp;
        5'd16: t_r[10] <= t_r[6] + mp;
        5'd17: t_r[11] <= t_r[8] + mp;
        default: t_r[2] <= t_r[10] + mp;
      endcase
    end
  end

  // output mapping of t_r[2]
  logic signed [VW:0] r;
  logic [VW:0] sh;
  assign r = (VW+1)'(t_r[2]) + (VW+1)'(QONE);
  assign sh = (r + (VW+1)'(256)) >> 9;
  assign noise = r[VW] ? 16'd0 : ((sh > (VW+1)'(65535)) ? 16'hFFFF : sh[15:0]);
endmodule
`default_nettype wire

FILE: rtl/pn3_ctrl.sv
// Controller: sequences table reads and multiplications for one evaluation.
`default_nettype none
module pn3_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       mdone,
  input  wire logic       out_free,
  output logic            busy,
  output logic [2:0]      step,
  output logic            tab_rd,
  output logic [3:0]      tsel,
  output logic [4:0]      mstep,
  output logic            mstart,
  output logic            fin
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CAP  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] tsel_r, tsel_nxt;
  logic [4:0] mstep_r, mstep_nxt;

  assign busy = state_r != S_IDLE;
  assign tsel = tsel_r;
  assign mstep = mstep_r;
  assign tab_rd = state_r == S_RD;
  assign step = (state_r == S_CAP) ? 3'd1 : 3'd0;
  assign mstart = state_r == S_MUL;
  assign fin = (state_r == S_OUT) && out_free;

  always_comb begin
    state_nxt = state_r;
    tsel_nxt = tsel_r;
    mstep_nxt = mstep_r;
    case (state_r)
      S_IDLE: if (start) begin state_nxt = S_RD; tsel_nxt = '0; end
      S_RD: state_nxt = S_CAP;
      S_CAP: begin
        if (tsel_r == 4'd13) begin
          state_nxt = S_MUL;
          mstep_nxt = '0;
        end else begin
          tsel_nxt = tsel_r + 4'd1;
          state_nxt = S_RD;
        end
      end
      S_MUL: state_nxt = S_WAIT;
      S_WAIT: begin
        if (mdone) begin
          if (mstep_r == 5'd18) state_nxt = S_OUT;
          else begin
            mstep_nxt = mstep_r + 5'd1;
            state_nxt = S_MUL;
          end
        end
      end
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tsel_r <= '0;
      mstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      tsel_r <= tsel_nxt;
      mstep_r <= mstep_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/perlin_noise_3d.sv
// Top level of the 3D improved-noise block.
// A load transaction (command 0) writes one byte of the 256-entry permutation
// memory and returns nothing. An evaluate transaction (command 1) holds
// in_stall high while it runs, so no new transaction is accepted until it is
// done: fourteen dependent reads of the permutation memory through its one
// read port, nineteen rounded Q.24 multiplications on one shared multiplier
// (fade, then seven lerps) and the hand-over of the result to the output
// register. The result sits in that register until taken; the next
// evaluation may start meanwhile but cannot finish until that register frees,
// and the input stays stalled for as long as it waits.
`default_nettype none
module perlin_noise_3d import pn3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_table_index,
  input  wire logic [7:0]  in_table_value,
  input  wire logic [23:0] in_x_coord,
  input  wire logic [23:0] in_y_coord,
  input  wire logic [23:0] in_z_coord,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_noise_value
);
  logic busy, acc, start, mdone, tab_rd, mstart, fin, out_free;
  logic [2:0] step;
  logic [3:0] tsel;
  logic [4:0] mstep;
  logic [15:0] noise;
  logic out_valid_r;
  logic [15:0] out_r;

  // stall while an evaluation is running
  assign in_stall = busy;
  assign acc = in_valid && !busy;
  assign start = acc && (in_command == CMD_EVAL);
  assign out_free = !out_valid_r || !out_stall;

  pn3_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .mdone(mdone),
    .out_free(out_free), .busy(busy), .step(step), .tab_rd(tab_rd), .tsel(tsel),
    .mstep(mstep), .mstart(mstart), .fin(fin));

  pn3_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (.clk(clk), .rst_n(rst_n),
    .wr_en(acc && (in_command == CMD_LOAD)), .wr_addr(in_table_index),
    .wr_data(in_table_value),
    .x_in(in_x_coord), .y_in(in_y_coord), .z_in(in_z_coord), .step(step),
    .mstep(mstep), .tab_rd(tab_rd), .tsel(tsel), .load(start), .mstart(mstart),
    .mdone(mdone), .noise(noise));

  // hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (fin) out_r <= noise;
  end

  assign out_valid = out_valid_r;
  assign out_noise_value = out_r;
endmodule
`default_nettype wire
